FILE: src/ftcap_pkg.sv
package ftcap_pkg;

  localparam int unsigned FRAME_W  = 8;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_ID   = 3'd1,
    ST_UNKNOWN  = 3'd2,
    ST_TOO_DEEP = 3'd3,
    ST_NO_ROOT  = 3'd4
  } status_e;

  localparam logic ACT_SET    = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic SIDE_SOURCE = 1'b0;
  localparam logic SIDE_TARGET = 1'b1;

  // Request from the sequencer to the frame table.
  typedef struct packed {
    logic               wr_en;
    logic [FRAME_W-1:0] wr_child;
    logic [FRAME_W-1:0] wr_parent;
    logic               rd_en;
    logic [FRAME_W-1:0] rd_frame;
  } tbl_req_t;

  // Both fields are registered reads of rd_frame, valid the cycle after rd_en.
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] parent;
  } tbl_rsp_t;

endpackage

FILE: src/ftcap_frame_table.sv
module ftcap_frame_table #(
  parameter int unsigned FRAME_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ftcap_pkg::tbl_req_t req_i,
  output ftcap_pkg::tbl_rsp_t rsp_o
);

  localparam int unsigned ID_SPAN     = 2 ** ftcap_pkg::FRAME_W;
  localparam int unsigned TABLE_DEPTH = (FRAME_COUNT < ID_SPAN) ? FRAME_COUNT : ID_SPAN;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  logic [ftcap_pkg::FRAME_W-1:0] parent_mem [TABLE_DEPTH];
  logic [ftcap_pkg::FRAME_W-1:0] parent_q;
  logic [TABLE_DEPTH-1:0]        present_q;
  logic [TABLE_DEPTH-1:0]        present_d;
  logic                          rd_present_q;
  logic                          clr_pend_q;
  logic [IDX_W-1:0]              clr_idx_q;

  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] par_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_idx  = req_i.wr_child[IDX_W-1:0];
  assign par_idx = req_i.wr_parent[IDX_W-1:0];
  assign rd_idx  = req_i.rd_frame[IDX_W-1:0];

  always_comb begin
    present_d = present_q;
    if (req_i.wr_en) begin
      present_d[wr_idx]  = 1'b1;
      present_d[par_idx] = 1'b1;
    end
  end

  // Parent store: one write port, one registered read port. A frame first seen
  // as a parent has its entry zeroed in the cycle after the set.
  always_ff @(posedge clk_i) begin
    if (clr_pend_q) begin
      parent_mem[clr_idx_q] <= '0;
    end else if (req_i.wr_en) begin
      parent_mem[wr_idx] <= req_i.wr_parent;
    end
    if (req_i.rd_en) begin
      parent_q <= parent_mem[rd_idx];
    end
  end

  // Presence bits; only a present frame's parent entry is ever used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q    <= '0;
      rd_present_q <= 1'b0;
      clr_pend_q   <= 1'b0;
      clr_idx_q    <= '0;
    end else begin
      present_q  <= present_d;
      clr_pend_q <= req_i.wr_en && !present_q[par_idx] && (par_idx != wr_idx);
      if (req_i.wr_en) begin
        clr_idx_q <= par_idx;
      end
      if (req_i.rd_en) begin
        rd_present_q <= present_q[rd_idx];
      end
    end
  end

  assign rsp_o.present = rd_present_q;
  assign rsp_o.parent  = rd_present_q ? parent_q : '0;

endmodule

FILE: src/frame_tree_common_ancestor_path_unit.sv
// Channel   Direction  Handshake              Payload
// request   in         in_valid_i/in_stall_o  action_i, first_frame_i, second_frame_i
// result    out        out_valid_o/out_stall_i status_o, side_o, frame_id_o,
//                                             frame_valid_o, last_o
//
// A lookup reads the start frame, walks the source chain, then the target chain,
// checks the roots, strips the shared upper part and emits the path frames (one
// empty result for an empty path); each walk step is one registered table read.
// Errors end the lookup early. Result stalls lengthen a request.
// rst_ni clears the presence map; parent entries are read only for present frames.
// A stalled result holds its output register; in_stall_o is high while a request
// is in progress, and a request may be taken while its predecessor's last result
// still waits.
module frame_tree_common_ancestor_path_unit #(
  parameter int unsigned FRAME_COUNT = 256,
  parameter int unsigned DEPTH_LIMIT = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [ftcap_pkg::FRAME_W-1:0]  first_frame_i,
  input  logic [ftcap_pkg::FRAME_W-1:0]  second_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ftcap_pkg::STATUS_W-1:0] status_o,
  output logic                           side_o,
  output logic [ftcap_pkg::FRAME_W-1:0]  frame_id_o,
  output logic                           frame_valid_o,
  output logic                           last_o
);

  localparam int unsigned CHAIN_DEPTH = DEPTH_LIMIT + 2;
  localparam int unsigned CNT_W       = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned CI_W        = $clog2(CHAIN_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_ROOT,
    S_STRIP,
    S_EMIT,
    S_SINGLE
  } state_e;

  state_e                        state_q;
  logic [ftcap_pkg::FRAME_W-1:0] target_q;
  logic [ftcap_pkg::FRAME_W-1:0] frame_q;
  logic [CNT_W-1:0]              count_q;
  logic                          walk_side_q;
  logic [CNT_W-1:0]              slen_q;
  logic [CNT_W-1:0]              tlen_q;
  logic [CNT_W-1:0]              idx_q;
  logic                          emit_side_q;
  ftcap_pkg::status_e            status_q;

  logic [ftcap_pkg::FRAME_W-1:0] src_chain_q [CHAIN_DEPTH];
  logic [ftcap_pkg::FRAME_W-1:0] tgt_chain_q [CHAIN_DEPTH];

  logic                          out_valid_q;
  ftcap_pkg::status_e            out_status_q;
  logic                          out_side_q;
  logic [ftcap_pkg::FRAME_W-1:0] out_id_q;
  logic                          out_fvalid_q;
  logic                          out_last_q;

  ftcap_pkg::tbl_req_t tbl_req;
  ftcap_pkg::tbl_rsp_t tbl_rsp;

  logic [ftcap_pkg::FRAME_W-1:0] next_frame;
  logic                          cur_in_range;
  logic                          step_ok;
  logic [CNT_W-1:0]              count_inc;
  logic [CNT_W-1:0]              idx_inc;
  logic [CNT_W-1:0]              slen_m1;
  logic [CNT_W-1:0]              tlen_m1;
  logic [CI_W-1:0]               src_idx;
  logic [CI_W-1:0]               tgt_idx;
  logic [ftcap_pkg::FRAME_W-1:0] src_rd;
  logic [ftcap_pkg::FRAME_W-1:0] tgt_rd;
  logic                          tops_match;
  logic                          out_free;
  logic                          out_load;
  logic                          in_accept;
  logic                          lookup_start;
  logic                          set_ok;
  logic                          lookup_ok;
  logic                          emit_last;

  function automatic logic id_in_range(input logic [ftcap_pkg::FRAME_W-1:0] id);
    return 32'(id) < FRAME_COUNT;
  endfunction

  ftcap_frame_table #(
    .FRAME_COUNT(FRAME_COUNT)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && ((state_q == S_EMIT) || (state_q == S_SINGLE));

  assign set_ok    = (first_frame_i != '0) && id_in_range(first_frame_i) &&
                     id_in_range(second_frame_i);
  assign lookup_ok = (first_frame_i != '0) && (second_frame_i != '0) &&
                     id_in_range(first_frame_i) && id_in_range(second_frame_i);
  assign lookup_start = in_accept && (action_i == ftcap_pkg::ACT_LOOKUP) && lookup_ok;

  // Walk step: frame_q is the frame whose table entry was read last cycle.
  assign next_frame   = tbl_rsp.parent;
  assign cur_in_range = id_in_range(frame_q);
  assign step_ok      = (state_q == S_WALK) && cur_in_range && tbl_rsp.present;
  assign count_inc    = count_q + CNT_W'(1);
  assign idx_inc      = idx_q + CNT_W'(1);

  // Read the start frame on accept, then the parent just returned; at the end of
  // the source chain read the target frame instead.
  always_comb begin
    tbl_req.wr_en     = in_accept && (action_i == ftcap_pkg::ACT_SET) && set_ok;
    tbl_req.wr_child  = first_frame_i;
    tbl_req.wr_parent = second_frame_i;
    tbl_req.rd_en     = lookup_start || step_ok;
    if (state_q == S_IDLE) begin
      tbl_req.rd_frame = second_frame_i;
    end else if (next_frame == '0) begin
      tbl_req.rd_frame = target_q;
    end else begin
      tbl_req.rd_frame = next_frame;
    end
  end

  // Chain reads: top entries while stripping, emit index while emitting.
  assign slen_m1    = slen_q - CNT_W'(1);
  assign tlen_m1    = tlen_q - CNT_W'(1);
  assign src_idx    = (state_q == S_EMIT) ? idx_q[CI_W-1:0] : slen_m1[CI_W-1:0];
  assign tgt_idx    = (state_q == S_EMIT) ? idx_q[CI_W-1:0] : tlen_m1[CI_W-1:0];
  assign src_rd     = src_chain_q[src_idx];
  assign tgt_rd     = tgt_chain_q[tgt_idx];
  assign tops_match = (src_rd == tgt_rd);

  assign emit_last = (emit_side_q == ftcap_pkg::SIDE_SOURCE) ?
                     ((idx_inc == slen_q) && (tlen_q == '0)) : (idx_inc == tlen_q);

  // Chain scratch: written at the walk count, no reset needed.
  always_ff @(posedge clk_i) begin
    if (step_ok) begin
      if (walk_side_q == ftcap_pkg::SIDE_SOURCE) begin
        src_chain_q[count_q[CI_W-1:0]] <= frame_q;
      end else begin
        tgt_chain_q[count_q[CI_W-1:0]] <= frame_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      target_q     <= '0;
      frame_q      <= '0;
      count_q      <= '0;
      walk_side_q  <= ftcap_pkg::SIDE_SOURCE;
      slen_q       <= '0;
      tlen_q       <= '0;
      idx_q        <= '0;
      emit_side_q  <= ftcap_pkg::SIDE_SOURCE;
      status_q     <= ftcap_pkg::ST_OK;
      out_valid_q  <= 1'b0;
      out_status_q <= ftcap_pkg::ST_OK;
      out_side_q   <= 1'b0;
      out_id_q     <= '0;
      out_fvalid_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      // Drop a result once it is taken, unless a new one loads below.
      if (out_valid_q && !out_stall_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (action_i == ftcap_pkg::ACT_SET) begin
              if (set_ok) begin
                status_q <= ftcap_pkg::ST_OK;
              end else begin
                status_q <= ftcap_pkg::ST_BAD_ID;
              end
              state_q  <= S_SINGLE;
            end else if (lookup_ok) begin
              frame_q     <= second_frame_i;
              target_q    <= first_frame_i;
              count_q     <= '0;
              walk_side_q <= ftcap_pkg::SIDE_SOURCE;
              state_q     <= S_WALK;
            end else begin
              status_q <= ftcap_pkg::ST_BAD_ID;
              state_q  <= S_SINGLE;
            end
          end
        end

        S_WALK: begin
          if (!cur_in_range || !tbl_rsp.present) begin
            status_q <= ftcap_pkg::ST_UNKNOWN;
            state_q  <= S_SINGLE;
          end else if (count_inc == CNT_W'(CHAIN_DEPTH)) begin
            // Covers loops in the table as well.
            status_q <= ftcap_pkg::ST_TOO_DEEP;
            state_q  <= S_SINGLE;
          end else if (next_frame == '0) begin
            if (walk_side_q == ftcap_pkg::SIDE_SOURCE) begin
              // Source chain done: the target read is already issued.
              slen_q      <= count_inc;
              frame_q     <= target_q;
              count_q     <= '0;
              walk_side_q <= ftcap_pkg::SIDE_TARGET;
            end else begin
              tlen_q  <= count_inc;
              state_q <= S_ROOT;
            end
          end else begin
            count_q <= count_inc;
            frame_q <= next_frame;
          end
        end

        S_ROOT: begin
          if ((slen_q == '0) || (tlen_q == '0) || !tops_match) begin
            status_q <= ftcap_pkg::ST_NO_ROOT;
            state_q  <= S_SINGLE;
          end else begin
            state_q <= S_STRIP;
          end
        end

        S_STRIP: begin
          if ((slen_q != '0) && (tlen_q != '0) && tops_match) begin
            slen_q <= slen_m1;
            tlen_q <= tlen_m1;
          end else if ((slen_q == '0) && (tlen_q == '0)) begin
            status_q <= ftcap_pkg::ST_OK;
            state_q  <= S_SINGLE;
          end else begin
            idx_q       <= '0;
            emit_side_q <= (slen_q == '0) ? ftcap_pkg::SIDE_TARGET : ftcap_pkg::SIDE_SOURCE;
            state_q     <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= ftcap_pkg::ST_OK;
            out_side_q   <= emit_side_q;
            out_id_q     <= (emit_side_q == ftcap_pkg::SIDE_SOURCE) ? src_rd : tgt_rd;
            out_fvalid_q <= 1'b1;
            out_last_q   <= emit_last;
            if (emit_last) begin
              state_q <= S_IDLE;
            end else if ((emit_side_q == ftcap_pkg::SIDE_SOURCE) && (idx_inc == slen_q)) begin
              emit_side_q <= ftcap_pkg::SIDE_TARGET;
              idx_q       <= '0;
            end else begin
              idx_q <= idx_inc;
            end
          end
        end

        S_SINGLE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_side_q   <= ftcap_pkg::SIDE_SOURCE;
            out_id_q     <= '0;
            out_fvalid_q <= 1'b0;
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign side_o        = out_side_q;
  assign frame_id_o    = out_id_q;
  assign frame_valid_o = out_fvalid_q;
  assign last_o        = out_last_q;

endmodule

FILE: src/ftcap_checker.sv
module ftcap_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ftcap_pkg::STATUS_W-1:0] status_o,
  input logic                           side_o,
  input logic [ftcap_pkg::FRAME_W-1:0]  frame_id_o,
  input logic                           frame_valid_o,
  input logic                           last_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(side_o) &&
      $stable(frame_id_o) && $stable(frame_valid_o) && $stable(last_o))
    else $error("stalled result changed");

  // The block stays busy after taking a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken but block not busy");

  // A path frame still to follow means the request is still in progress.
  a_busy_mid_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("ready while path incomplete");

  // Error results are single, empty and last.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != 3'(ftcap_pkg::ST_OK)) |->
      last_o && !frame_valid_o && (frame_id_o == '0) && !side_o)
    else $error("malformed error result");

  // Path frames only come with an ok status.
  a_frame_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_valid_o |-> (status_o == 3'(ftcap_pkg::ST_OK)))
    else $error("path frame with error status");

endmodule

bind frame_tree_common_ancestor_path_unit ftcap_checker u_ftcap_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned FRAME_W  = ftcap_pkg::FRAME_W;
  localparam int unsigned STATUS_W = ftcap_pkg::STATUS_W;

  // A chain may hold DEPTH_LIMIT+1 frames; the walk gives up once it reaches
  // DEPTH_LIMIT+2 of them.
  localparam int unsigned FRAME_COUNT = 256;
  localparam int unsigned DEPTH_LIMIT = 16;
  localparam int unsigned CHAIN_MAX   = DEPTH_LIMIT + 2;

  // Cycles with no handshake on either channel before the run is declared hung.
  // The limit lies well above the long receiver hold-off and any lookup.
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_OFF    = 300;
  localparam int unsigned DRAIN_WAIT  = 150;
  localparam int unsigned PRINT_CAP   = 40;

  typedef logic [CHAIN_MAX-1:0][FRAME_W-1:0] chain_t;

  typedef struct packed {
    ftcap_pkg::status_e status;
    logic               side;
    logic [FRAME_W-1:0] frame;
    logic               frame_ok;
    logic               last;
  } path_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                action_i;
  logic [FRAME_W-1:0]  first_frame_i;
  logic [FRAME_W-1:0]  second_frame_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic                side_o;
  logic [FRAME_W-1:0]  frame_id_o;
  logic                frame_valid_o;
  logic                last_o;

  frame_tree_common_ancestor_path_unit #(
    .FRAME_COUNT(FRAME_COUNT),
    .DEPTH_LIMIT(DEPTH_LIMIT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .first_frame_i (first_frame_i),
    .second_frame_i(second_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .side_o        (side_o),
    .frame_id_o    (frame_id_o),
    .frame_valid_o (frame_valid_o),
    .last_o        (last_o)
  );

  // Mirror of the frame table, updated as each request is accepted.
  logic [FRAME_W-1:0] parent_of   [FRAME_COUNT];
  logic               frame_known [FRAME_COUNT];

  // Results still owed by the block, oldest first.
  path_item_t expected_path_items[$];

  // Frames already placed in the tree being built by the current round.
  bit in_round [FRAME_COUNT];

  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;

  // Idling controls: the sender and receiver insert random bursts while these
  // are set; hold_cycles asks the receiver for one long hold-off.
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_cycles;
  int unsigned rx_burst_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Path predictor
  // ---------------------------------------------------------------------------

  // Walk from start up to a root, recording each frame on the way. A frame not
  // in the table ends the walk as unknown; a chain that grows too long (a loop
  // included) ends it as too deep.
  function automatic ftcap_pkg::status_e trace_to_root(input logic [FRAME_W-1:0] start,
                                                       output chain_t path,
                                                       output int unsigned len);
    logic [FRAME_W-1:0] f;
    int unsigned        n;
    f    = start;
    n    = 0;
    path = '0;
    len  = 0;
    while (f != '0) begin
      if (int'(f) >= FRAME_COUNT || !frame_known[f]) return ftcap_pkg::ST_UNKNOWN;
      path[n] = f;
      f       = parent_of[f];
      n++;
      if (n >= CHAIN_MAX) return ftcap_pkg::ST_TOO_DEEP;
    end
    len = n;
    return ftcap_pkg::ST_OK;
  endfunction

  // Append one owed result.
  task automatic owe_result(input path_item_t item);
    expected_path_items.insert(expected_path_items.size(), item);
  endtask

  // Queue a lone result that carries no frame: errors, set replies, empty paths.
  task automatic expect_single(input ftcap_pkg::status_e st);
    path_item_t item;
    item          = '0;
    item.status   = st;
    item.side     = ftcap_pkg::SIDE_SOURCE;
    item.last     = 1'b1;
    owe_result(item);
  endtask

  task automatic predict_path(input logic act, input logic [FRAME_W-1:0] first_id,
                              input logic [FRAME_W-1:0] second_id);
    chain_t             src_path;
    chain_t             tgt_path;
    int unsigned        src_len;
    int unsigned        tgt_len;
    ftcap_pkg::status_e st;
    path_item_t         item;
    if (act == ftcap_pkg::ACT_SET) begin
      if (first_id == '0 || int'(first_id) >= FRAME_COUNT || int'(second_id) >= FRAME_COUNT)
      begin
        expect_single(ftcap_pkg::ST_BAD_ID);
      end else begin
        frame_known[first_id]  = 1'b1;
        frame_known[second_id] = 1'b1;
        parent_of[first_id]    = second_id;
        expect_single(ftcap_pkg::ST_OK);
      end
      return;
    end
    if (first_id == '0 || second_id == '0 ||
        int'(first_id) >= FRAME_COUNT || int'(second_id) >= FRAME_COUNT) begin
      expect_single(ftcap_pkg::ST_BAD_ID);
      return;
    end
    // Source chain first, fully, then the target chain.
    tgt_len = 0;
    st = trace_to_root(second_id, src_path, src_len);
    if (st == ftcap_pkg::ST_OK) st = trace_to_root(first_id, tgt_path, tgt_len);
    if (st == ftcap_pkg::ST_OK && (src_len == 0 || tgt_len == 0 ||
                                   src_path[src_len-1] != tgt_path[tgt_len-1]))
      st = ftcap_pkg::ST_NO_ROOT;
    if (st != ftcap_pkg::ST_OK) begin
      expect_single(st);
      return;
    end
    // Drop the shared upper part of both chains.
    while (src_len > 0 && tgt_len > 0 && src_path[src_len-1] == tgt_path[tgt_len-1]) begin
      src_len--;
      tgt_len--;
    end
    if (src_len + tgt_len == 0) begin
      expect_single(ftcap_pkg::ST_OK);
      return;
    end
    for (int unsigned i = 0; i < src_len; i++) begin
      item.status   = ftcap_pkg::ST_OK;
      item.side     = ftcap_pkg::SIDE_SOURCE;
      item.frame    = src_path[i];
      item.frame_ok = 1'b1;
      item.last     = (i + 1 == src_len) && (tgt_len == 0);
      owe_result(item);
    end
    for (int unsigned i = 0; i < tgt_len; i++) begin
      item.status   = ftcap_pkg::ST_OK;
      item.side     = ftcap_pkg::SIDE_TARGET;
      item.frame    = tgt_path[i];
      item.frame_ok = 1'b1;
      item.last     = (i + 1 == tgt_len);
      owe_result(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance.
  // Valid stays high into the next request unless an idle burst is drawn.
  task automatic send_request(input logic act, input logic [FRAME_W-1:0] first_id,
                              input logic [FRAME_W-1:0] second_id);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    first_frame_i  <= first_id;
    second_frame_i <= second_id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_path(act, first_id, second_id);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else if (rx_burst_left != 0) begin
      out_stall_i <= 1'b1;
      rx_burst_left--;
    end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
      // The high cycle set here counts as the first of the burst.
      out_stall_i   <= 1'b1;
      rx_burst_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    path_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_path_items.size() == 0) begin
        report_mismatch("unexpected result, frame", frame_id_o, 0);
      end else begin
        want = expected_path_items.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (side_o !== want.side) report_mismatch("side", side_o, want.side);
        if (frame_id_o !== want.frame) report_mismatch("frame_id", frame_id_o, want.frame);
        if (frame_valid_o !== want.frame_ok)
          report_mismatch("frame_valid", frame_valid_o, want.frame_ok);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results owed", QUIET_LIMIT,
             expected_path_items.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [FRAME_W-1:0] pick_fresh_frame();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'($urandom_range(1, FRAME_COUNT - 1));
    while (in_round[f]) f = FRAME_W'($urandom_range(1, FRAME_COUNT - 1));
    in_round[f] = 1'b1;
    return f;
  endfunction

  // Zero ids are refused: a zero child on set, either zero frame on lookup.
  task automatic test_bad_ids();
    send_request(ftcap_pkg::ACT_SET, 8'd0, 8'd0);
    send_request(ftcap_pkg::ACT_SET, 8'd0, 8'd255);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd0, 8'd5);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd5, 8'd0);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd0, 8'd0);
  endtask

  // Frames never set; the source walk is checked before the target walk.
  task automatic test_unknown_frames();
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd200, 8'd201);
    send_request(ftcap_pkg::ACT_SET, 8'd10, 8'd0);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd10, 8'd201);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd201, 8'd10);
  endtask

  // Small tree under frame 10: cousins, ancestor, descendant and same frame.
  task automatic test_small_tree();
    send_request(ftcap_pkg::ACT_SET, 8'd11, 8'd10);
    send_request(ftcap_pkg::ACT_SET, 8'd12, 8'd11);
    send_request(ftcap_pkg::ACT_SET, 8'd13, 8'd10);
    send_request(ftcap_pkg::ACT_SET, 8'd255, 8'd13);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd12, 8'd255);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd10, 8'd12);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd12, 8'd10);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd13, 8'd13);
  endtask

  // Loops in the table read as too deep; separate trees have no common root.
  task automatic test_loops_and_roots();
    send_request(ftcap_pkg::ACT_SET, 8'd20, 8'd21);
    send_request(ftcap_pkg::ACT_SET, 8'd21, 8'd20);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd10, 8'd20);
    send_request(ftcap_pkg::ACT_SET, 8'd40, 8'd40);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd40, 8'd10);
    send_request(ftcap_pkg::ACT_SET, 8'd30, 8'd31);
    send_request(ftcap_pkg::ACT_LOOKUP, 8'd30, 8'd12);
  endtask

  // Build fresh random trees from frames not used in this round, then query them.
  // Parents come from this round only, so the new trees have no loops of their own.
  task automatic grow_and_query(input int unsigned nodes);
    logic [FRAME_W-1:0] members[$];
    logic [FRAME_W-1:0] f;
    logic [FRAME_W-1:0] p;
    foreach (in_round[i]) in_round[i] = 1'b0;
    repeat (nodes) begin
      f = pick_fresh_frame();
      if (members.size() == 0 || $urandom_range(0, 9) == 0) p = '0;
      else if ($urandom_range(0, 1) == 0) p = members[members.size()-1];
      else p = members[$urandom_range(0, members.size() - 1)];
      send_request(ftcap_pkg::ACT_SET, f, p);
      members = {members, f};
    end
    repeat (nodes) begin
      case ($urandom_range(0, 9))
        0: send_request(1'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, 255)),
                        FRAME_W'($urandom_range(0, 255)));
        1: send_request(ftcap_pkg::ACT_LOOKUP, members[$urandom_range(0, members.size() - 1)],
                        FRAME_W'($urandom_range(1, 255)));
        default: send_request(ftcap_pkg::ACT_LOOKUP,
                              members[$urandom_range(0, members.size() - 1)],
                              members[$urandom_range(0, members.size() - 1)]);
      endcase
    end
  endtask

  // Two chains from one root, with tip depths len_a and len_b; reaches the
  // depth limit and the longest paths.
  task automatic grow_fork_and_query(input int unsigned len_a, input int unsigned len_b);
    logic [FRAME_W-1:0] members[$];
    logic [FRAME_W-1:0] root;
    logic [FRAME_W-1:0] tip_a;
    logic [FRAME_W-1:0] tip_b;
    logic [FRAME_W-1:0] f;
    foreach (in_round[i]) in_round[i] = 1'b0;
    root = pick_fresh_frame();
    send_request(ftcap_pkg::ACT_SET, root, 8'd0);
    members = {members, root};
    tip_a = root;
    repeat (len_a - 1) begin
      f = pick_fresh_frame();
      send_request(ftcap_pkg::ACT_SET, f, tip_a);
      tip_a = f;
      members = {members, f};
    end
    tip_b = root;
    repeat (len_b - 1) begin
      f = pick_fresh_frame();
      send_request(ftcap_pkg::ACT_SET, f, tip_b);
      tip_b = f;
      members = {members, f};
    end
    send_request(ftcap_pkg::ACT_LOOKUP, tip_b, tip_a);
    send_request(ftcap_pkg::ACT_LOOKUP, tip_a, tip_b);
    repeat (4)
      send_request(ftcap_pkg::ACT_LOOKUP, members[$urandom_range(0, members.size() - 1)],
                   members[$urandom_range(0, members.size() - 1)]);
  endtask

  task automatic test_deep_forks();
    grow_fork_and_query(DEPTH_LIMIT + 1, DEPTH_LIMIT + 1);
    grow_fork_and_query(DEPTH_LIMIT + 2, $urandom_range(1, DEPTH_LIMIT + 1));
  endtask

  // Hold the receiver off for a long stretch while requests keep coming, so
  // the block fills and stalls its input.
  task automatic test_backpressure();
    hold_cycles = HOLD_OFF;
    grow_and_query(12);
  endtask

  task automatic test_random_forest();
    while (requests_sent < 350) begin
      case ($urandom_range(0, 4))
        0: grow_fork_and_query($urandom_range(1, DEPTH_LIMIT + 2),
                               $urandom_range(1, DEPTH_LIMIT + 1));
        default: grow_and_query($urandom_range(6, 24));
      endcase
    end
  endtask

  // Last stretch with no idling on either side.
  task automatic test_steady_stream();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    grow_and_query(20);
    grow_fork_and_query($urandom_range(2, DEPTH_LIMIT + 1), $urandom_range(2, DEPTH_LIMIT + 1));
  endtask

  initial begin
    // Drive every input to a known value and hold reset, then release it.
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ftcap_pkg::ACT_SET;
    first_frame_i  = '0;
    second_frame_i = '0;
    out_stall_i    = 1'b0;
    mismatches     = 0;
    requests_sent  = 0;
    results_seen   = 0;
    hold_cycles    = 0;
    rx_burst_left  = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    foreach (parent_of[i]) begin
      parent_of[i]   = '0;
      frame_known[i] = 1'b0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_bad_ids();
    test_unknown_frames();
    test_small_tree();
    test_loops_and_roots();
    test_deep_forks();
    test_backpressure();
    test_random_forest();
    test_steady_stream();

    in_valid_i <= 1'b0;
    // Wait for every owed result, then a little longer to catch strays.
    while (expected_path_items.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
